### sv/clte_pkg.sv
// Shared constants, micro-op codes and control types of the code length table encoder.
package clte_pkg;

  localparam int NUM_SYMBOLS = 256;
  localparam int CNT_W       = $clog2(NUM_SYMBOLS + 1);
  localparam int LEN_W       = 5;
  localparam int NIB_W       = 4;
  localparam int PC_W        = 5;

  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(22);
  localparam logic [LEN_W:0]   DELTA_MOD = (LEN_W + 1)'(23);
  localparam logic [LEN_W-1:0] DELTA_LO  = LEN_W'(19);
  localparam logic [NIB_W-1:0] ESC_NIB   = NIB_W'(4);
  localparam logic [NIB_W-1:0] EQUAL_TAG = NIB_W'(8);
  localparam logic [NIB_W-1:0] ZERO_TAG  = NIB_W'(12);
  localparam logic [CNT_W-1:0] LAST_SYM  = CNT_W'(NUM_SYMBOLS - 1);

  typedef enum logic [3:0] {
    OP_WAIT  = 4'd0,
    OP_JZ    = 4'd1,
    OP_JEQ   = 4'd2,
    OP_LDZ   = 4'd3,
    OP_LDE   = 4'd4,
    OP_RUN   = 4'd5,
    OP_DELTA = 4'd6,
    OP_ESC2  = 4'd7,
    OP_INCE  = 4'd8,
    OP_INCZ  = 4'd9,
    OP_COUNT = 4'd10,
    OP_PAD   = 4'd11,
    OP_FLUSH = 4'd12,
    OP_END   = 4'd13
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic hold;
    logic branch;
  } stat_t;

endpackage

### sv/clte_ucode.sv
// Read-only microcode table of the encoder sequencer.
module clte_ucode
  import clte_pkg::*;
(
  input  logic [PC_W-1:0] pc_i,
  output ctrl_t           ctrl_o
);

  always_comb begin
    case (pc_i)
      PC_W'(0):  ctrl_o = '{op: OP_WAIT,  target: PC_W'(0)};
      PC_W'(1):  ctrl_o = '{op: OP_JZ,    target: PC_W'(10)};
      PC_W'(2):  ctrl_o = '{op: OP_LDZ,   target: PC_W'(0)};
      PC_W'(3):  ctrl_o = '{op: OP_RUN,   target: PC_W'(0)};
      PC_W'(4):  ctrl_o = '{op: OP_JEQ,   target: PC_W'(9)};
      PC_W'(5):  ctrl_o = '{op: OP_LDE,   target: PC_W'(0)};
      PC_W'(6):  ctrl_o = '{op: OP_RUN,   target: PC_W'(0)};
      PC_W'(7):  ctrl_o = '{op: OP_DELTA, target: PC_W'(13)};
      PC_W'(8):  ctrl_o = '{op: OP_ESC2,  target: PC_W'(13)};
      PC_W'(9):  ctrl_o = '{op: OP_INCE,  target: PC_W'(13)};
      PC_W'(10): ctrl_o = '{op: OP_LDE,   target: PC_W'(0)};
      PC_W'(11): ctrl_o = '{op: OP_RUN,   target: PC_W'(0)};
      PC_W'(12): ctrl_o = '{op: OP_INCZ,  target: PC_W'(13)};
      PC_W'(13): ctrl_o = '{op: OP_COUNT, target: PC_W'(20)};
      PC_W'(14): ctrl_o = '{op: OP_LDE,   target: PC_W'(0)};
      PC_W'(15): ctrl_o = '{op: OP_RUN,   target: PC_W'(0)};
      PC_W'(16): ctrl_o = '{op: OP_LDZ,   target: PC_W'(0)};
      PC_W'(17): ctrl_o = '{op: OP_RUN,   target: PC_W'(0)};
      PC_W'(18): ctrl_o = '{op: OP_PAD,   target: PC_W'(0)};
      PC_W'(19): ctrl_o = '{op: OP_END,   target: PC_W'(0)};
      PC_W'(20): ctrl_o = '{op: OP_FLUSH, target: PC_W'(0)};
      default:   ctrl_o = '{op: OP_FLUSH, target: PC_W'(0)};
    endcase
  end

endmodule

### sv/clte_datapath.sv
// Datapath of the encoder: run counters, delta coder, hold-back word and output register.
module clte_datapath
  import clte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [LEN_W-1:0] code_length_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [NIB_W-1:0] nibble_o,
  output logic             last_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] prev_q, prev_d;
  logic [CNT_W-1:0] eqrun_q, eqrun_d;
  logic [CNT_W-1:0] zrun_q, zrun_d;
  logic             odd_q, odd_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] work_q, work_d;
  logic [NIB_W-1:0] tag_q, tag_d;
  logic [LEN_W-1:0] delta_q, delta_d;
  logic [NIB_W-1:0] pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;
  logic [NIB_W-1:0] out_nib_q, out_nib_d;
  logic             out_last_q, out_last_d;
  logic             out_vld_q, out_vld_d;

  logic             out_free;
  logic             emit_ok;
  logic             emit_req;
  logic [NIB_W-1:0] emit_nib;
  logic             flush_req;
  logic [LEN_W:0]   dsum;
  logic [LEN_W-1:0] delta;
  logic             short_code;
  logic [NIB_W-1:0] short_nib;
  logic [1:0]       digit;
  logic [CNT_W-1:0] work_next;
  logic [LEN_W-1:0] len_sat;

  assign out_free = !out_vld_q || !out_stall_i;
  assign emit_ok  = !pend_vld_q || out_free;
  assign len_sat  = (code_length_i > MAX_LEN) ? MAX_LEN : code_length_i;

  assign dsum  = {1'b0, len_q} + DELTA_MOD - {1'b0, prev_q};
  assign delta = (dsum >= DELTA_MOD) ? LEN_W'(dsum - DELTA_MOD) : dsum[LEN_W-1:0];
  assign short_code = (delta <= LEN_W'(3)) || (delta >= DELTA_LO);
  assign short_nib  = (delta <= LEN_W'(3)) ? NIB_W'(delta + LEN_W'(4))
                                           : NIB_W'(delta - DELTA_LO);

  always_comb begin
    if (work_q[1:0] == 2'd0) begin
      digit     = 2'd3;
      work_next = (work_q - CNT_W'(4)) >> 2;
    end else begin
      digit     = work_q[1:0] - 2'd1;
      work_next = work_q >> 2;
    end
  end

  always_comb begin
    stat_o    = '{hold: 1'b0, branch: 1'b0};
    emit_req  = 1'b0;
    emit_nib  = '0;
    flush_req = 1'b0;
    cnt_d     = cnt_q;
    prev_d    = prev_q;
    eqrun_d   = eqrun_q;
    zrun_d    = zrun_q;
    len_d     = len_q;
    work_d    = work_q;
    tag_d     = tag_q;
    delta_d   = delta_q;
    case (ctrl_i.op)
      OP_WAIT: begin
        stat_o.hold = !in_valid_i;
        len_d       = len_sat;
      end
      OP_JZ: begin
        stat_o.branch = (len_q == '0);
      end
      OP_JEQ: begin
        stat_o.branch = (len_q == prev_q);
      end
      OP_LDZ: begin
        work_d = zrun_q;
        tag_d  = ZERO_TAG;
        zrun_d = '0;
      end
      OP_LDE: begin
        work_d  = eqrun_q;
        tag_d   = EQUAL_TAG;
        eqrun_d = '0;
      end
      OP_RUN: begin
        stat_o.hold = (work_q != '0);
        emit_req    = (work_q != '0);
        emit_nib    = tag_q | {2'b00, digit};
        if (work_q != '0 && emit_ok) begin
          work_d = work_next;
        end
      end
      OP_DELTA: begin
        stat_o.hold   = !emit_ok;
        stat_o.branch = short_code;
        emit_req      = 1'b1;
        emit_nib      = short_code ? short_nib : ESC_NIB;
        if (emit_ok) begin
          prev_d  = len_q;
          delta_d = delta;
        end
      end
      OP_ESC2: begin
        stat_o.hold   = !emit_ok;
        stat_o.branch = 1'b1;
        emit_req      = 1'b1;
        emit_nib      = NIB_W'(delta_q - LEN_W'(4));
      end
      OP_INCE: begin
        stat_o.branch = 1'b1;
        eqrun_d       = eqrun_q + CNT_W'(1);
      end
      OP_INCZ: begin
        stat_o.branch = 1'b1;
        zrun_d        = zrun_q + CNT_W'(1);
      end
      OP_COUNT: begin
        stat_o.branch = (cnt_q != LAST_SYM);
        cnt_d         = cnt_q + CNT_W'(1);
      end
      OP_PAD: begin
        stat_o.hold = odd_q && !emit_ok;
        emit_req    = odd_q;
        emit_nib    = '0;
      end
      OP_FLUSH: begin
        stat_o.hold   = pend_vld_q && !out_free;
        stat_o.branch = 1'b1;
        flush_req     = 1'b1;
      end
      OP_END: begin
        stat_o.hold   = pend_vld_q && !out_free;
        stat_o.branch = 1'b1;
        flush_req     = 1'b1;
        if (!(pend_vld_q && !out_free)) begin
          cnt_d   = '0;
          prev_d  = '0;
          eqrun_d = '0;
          zrun_d  = '0;
        end
      end
      default: begin
        stat_o.hold = 1'b0;
      end
    endcase
  end

  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    odd_d      = odd_q;
    out_nib_d  = out_nib_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && out_stall_i;
    if (emit_req && emit_ok) begin
      if (pend_vld_q) begin
        out_nib_d  = pend_q;
        out_last_d = 1'b0;
        out_vld_d  = 1'b1;
      end
      pend_d     = emit_nib;
      pend_vld_d = 1'b1;
      odd_d      = !odd_q;
    end else if (flush_req && pend_vld_q && out_free) begin
      out_nib_d  = pend_q;
      out_last_d = (ctrl_i.op == OP_END);
      out_vld_d  = 1'b1;
      pend_vld_d = 1'b0;
    end
    if (ctrl_i.op == OP_END && !(pend_vld_q && !out_free)) begin
      odd_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      prev_q     <= '0;
      eqrun_q    <= '0;
      zrun_q     <= '0;
      odd_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      prev_q     <= prev_d;
      eqrun_q    <= eqrun_d;
      zrun_q     <= zrun_d;
      odd_q      <= odd_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    work_q     <= work_d;
    tag_q      <= tag_d;
    delta_q    <= delta_d;
    pend_q     <= pend_d;
    out_nib_q  <= out_nib_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o  = (ctrl_i.op != OP_WAIT);
  assign out_valid_o = out_vld_q;
  assign nibble_o    = out_nib_q;
  assign last_o      = out_last_q;

endmodule

### sv/code_length_table_encoder.sv
// Top level of the code length table encoder: microcode sequencer and datapath.
//
//   Channel   Direction  Handshake                Payload
//   input     in         in_valid_i, in_stall_o   code_length_i[4:0]
//   output    out        out_valid_o, out_stall_i nibble_o[3:0], last_o
//
// Each length takes its own path through the microcode program (zero, repeated, new or escaped),
// and the run step repeats for each run word it emits. The last length of a table also flushes
// the final equal and zero runs and pads the stream to an even word count.
// Reset clears the step counter, all run counters and the output valid flag.
// An output stall holds the program at its current emitting or flush step once the hold-back word is full.
module code_length_table_encoder
  import clte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [LEN_W-1:0] code_length_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [NIB_W-1:0] nibble_o,
  output logic             last_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;
  stat_t           stat;

  clte_ucode u_ucode (
    .pc_i   (pc_q),
    .ctrl_o (ctrl)
  );

  clte_datapath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .code_length_i (code_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .nibble_o      (nibble_o),
    .last_o        (last_o)
  );

  always_comb begin
    if (stat.hold) begin
      pc_d = pc_q;
    end else if (stat.branch) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### sv/clte_checker.sv
// Port-level checker of the code length table encoder and its bind.
module clte_checker
  import clte_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [LEN_W-1:0] code_length_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [NIB_W-1:0] nibble_o,
  input logic             last_o
);

  logic par_q;
  logic out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= 1'b0;
    end else if (out_acc) begin
      par_q <= !par_q;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(nibble_o) && $stable(last_o))
    else $error("Stalled output word changed.");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken again before the previous length was processed.");

  a_even_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_o |-> par_q)
    else $error("Table stream ended on an odd word count.");

  a_code_length_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !$isunknown(code_length_i))
    else $error("Unknown code length taken.");

endmodule

bind code_length_table_encoder clte_checker u_clte_checker (.*);
